// ===== hdl/mlrf_pkg.sv =====
// Shared types, widths and constants for the loopback receive filter.
`default_nettype none

package mlrf_pkg;

	localparam int MAC_W  = 48;
	localparam int TIME_W = 48;
	localparam int LIFE_W = 32;
	localparam int LEN_W  = 16;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam logic [LEN_W-1:0] HEADER_BYTES = LEN_W'(14);
	// I/G bit: bit 0 of the first byte, which sits in the top byte
	localparam int GROUP_BIT = MAC_W - 8;

	localparam logic [MAC_W-1:0]  STATION_MAC_RST = '0;
	localparam logic              PROMISCUOUS_RST = 1'b1;
	localparam logic [LIFE_W-1:0] LIFETIME_RST    = LIFE_W'(60000);
	localparam logic [LEN_W-1:0]  MAX_LEN_RST     = LEN_W'(1514);

	typedef enum logic [1:0] {
		CFG_STATION_MAC  = 2'd0,
		CFG_PROMISCUOUS  = 2'd1,
		CFG_LIFETIME     = 2'd2,
		CFG_MAX_LENGTH   = 2'd3
	} cfg_index_t;

	typedef enum logic {
		OP_TRANSMIT = 1'b0,
		OP_RECEIVE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_INSERT,
		ST_RESULT
	} state_t;

	// One table entry as held in the RAM
	typedef struct packed {
		logic              used;
		logic [TIME_W-1:0] expiry;
		logic [MAC_W-1:0]  address;
	} entry_t;

	// Classification of a received frame header
	typedef struct packed {
		logic valid;
		logic group;
		logic mine;
	} class_t;

	typedef struct packed {
		logic accepted;
		logic sender_known;
		logic frame_valid;
		logic group_address;
		logic for_station;
		logic table_full;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/mlrf_item_if.sv =====
// Input channel carrying one frame header per transaction.
`default_nettype none

interface mlrf_item_if;
	import mlrf_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [MAC_W-1:0]  dest_address;
	logic [MAC_W-1:0]  source_address;
	logic [LEN_W-1:0]  frame_length;
	logic [TIME_W-1:0] current_time;

	modport source (
		output valid, operation, dest_address, source_address, frame_length, current_time,
		input  ready
	);

	modport sink (
		input  valid, operation, dest_address, source_address, frame_length, current_time,
		output ready
	);

endinterface

`default_nettype wire

// ===== hdl/mlrf_result_if.sv =====
// Output channel carrying one filter verdict per transaction.
`default_nettype none

interface mlrf_result_if;

	logic valid;
	logic ready;
	logic accepted;
	logic sender_known;
	logic frame_valid;
	logic group_address;
	logic for_station;
	logic table_full;

	modport source (
		output valid, accepted, sender_known, frame_valid, group_address, for_station,
		       table_full,
		input  ready
	);

	modport sink (
		input  valid, accepted, sender_known, frame_valid, group_address, for_station,
		       table_full,
		output ready
	);

endinterface

`default_nettype wire

// ===== hdl/mlrf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mlrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/mlrf_classify.sv =====
// Length, source and destination classification of a received frame header.
`default_nettype none

module mlrf_classify (
	input  wire logic [mlrf_pkg::MAC_W-1:0] dest_address,
	input  wire logic [mlrf_pkg::MAC_W-1:0] source_address,
	input  wire logic [mlrf_pkg::LEN_W-1:0] frame_length,
	input  wire logic [mlrf_pkg::MAC_W-1:0] station_mac,
	input  wire logic [mlrf_pkg::LEN_W-1:0] max_frame_length,
	output mlrf_pkg::class_t                cls
);
	import mlrf_pkg::*;

	logic in_range;
	logic bad_source;

	always_comb begin
		in_range   = (frame_length >= HEADER_BYTES) && (frame_length <= max_frame_length);
		bad_source = (source_address == '1) || (source_address == '0)
		          || (source_address == dest_address);
		cls.valid  = in_range && !bad_source;
		// broadcast also has the group bit set
		cls.group  = in_range && dest_address[GROUP_BIT];
		cls.mine   = cls.valid && (cls.group || (dest_address == station_mac));
	end

endmodule

`default_nettype wire

// ===== hdl/mac_loopback_receive_filter.sv =====
// Top level: loopback-suppressing receive filter with an aging source MAC table.
//
// Channels: item takes one frame header per transaction (operation, addresses, length,
// time stamp); result returns exactly one verdict per header, in order.
// Configuration: cfg_wr_en / cfg_index / cfg_data write station MAC, promiscuous flag,
// entry lifetime and maximum length; write only while no header is in flight.
// The table lives in one RAM word per entry {used, expiry, address}. A header of at
// least 14 bytes walks every entry, one read a cycle: matches are refreshed, expired
// entries freed and the first free slot noted; a transmitted header with no match is
// then written into that slot.
// Timing: a full header walks the table, drains the registered read, takes the insert
// slot and loads the result register, and only then is the next header taken; a header
// shorter than 14 bytes bypasses the table and goes straight to the result load. The
// walk over the single RAM read port sets the pace of a full header.
// Reset: configuration returns to its defaults and a clearing pass over all TABLE_ENTRIES
// entries marks every entry unused; item.ready stays low until it is done.
// Stall: the result register holds its transaction until taken; meanwhile the next
// header is accepted and processed, and waits for the register only at the end.
`default_nettype none

module mac_loopback_receive_filter #(
	parameter int TABLE_ENTRIES = mlrf_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire mlrf_pkg::cfg_index_t     cfg_index,
	input  wire logic [mlrf_pkg::MAC_W-1:0] cfg_data,
	mlrf_item_if.sink                     item,
	mlrf_result_if.source                 result
);
	import mlrf_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// configuration registers
	logic [MAC_W-1:0]  station_q;
	logic              prom_q;
	logic [LIFE_W-1:0] life_q;
	logic [LEN_W-1:0]  max_len_q;

	// header under work
	logic              op_q;
	logic [MAC_W-1:0]  dst_q;
	logic [MAC_W-1:0]  src_q;
	logic [LEN_W-1:0]  len_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] exp_q;   // saturated refresh/insert expiry
	logic              live_q;  // that expiry lies beyond now

	// walk bookkeeping
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              known_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	// output register
	logic              res_valid_q;
	result_t           res_q;

	// memory port
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;
	logic [$bits(entry_t)-1:0] mem_rdata;
	entry_t            rd_entry;

	// per-entry step
	logic              hit;
	logic              expired;
	logic              is_free;
	logic              upd_we;
	entry_t            upd_entry;

	logic              accept;
	logic              last_rd;
	logic              load_res;
	logic              do_insert;
	logic [TIME_W:0]   exp_sum;
	logic              long_frame;
	class_t            cls;
	result_t           res_d;

	mlrf_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_idx_q),
		.rdata (mem_rdata)
	);

	mlrf_classify u_classify (
		.dest_address     (dst_q),
		.source_address   (src_q),
		.frame_length     (len_q),
		.station_mac      (station_q),
		.max_frame_length (max_len_q),
		.cls              (cls)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= STATION_MAC_RST;
			prom_q    <= PROMISCUOUS_RST;
			life_q    <= LIFETIME_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_STATION_MAC: station_q <= cfg_data;
				CFG_PROMISCUOUS: prom_q    <= cfg_data[0];
				CFG_LIFETIME:    life_q    <= cfg_data[LIFE_W-1:0];
				CFG_MAX_LENGTH:  max_len_q <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	assign accept     = item.valid && item.ready;
	assign last_rd    = (rd_idx_q == LAST_IDX);
	assign long_frame = (item.frame_length >= HEADER_BYTES);
	assign exp_sum    = {1'b0, item.current_time} + {{(TIME_W + 1 - LIFE_W){1'b0}}, life_q};

	// Read-modify step on the entry returned by the RAM: refresh a match, free an
	// expired entry, otherwise leave it alone.
	always_comb begin
		rd_entry  = entry_t'(mem_rdata);
		hit       = rd_entry.used && (rd_entry.address == src_q);
		expired   = (rd_entry.expiry <= now_q);
		is_free   = !rd_entry.used || expired;
		upd_entry = rd_entry;
		upd_we    = 1'b0;
		if (hit) begin
			upd_entry.expiry = exp_q;
			upd_entry.used   = live_q;
			upd_we           = 1'b1;
		end else if (rd_entry.used && expired) begin
			upd_entry.used   = 1'b0;
			upd_we           = 1'b1;
		end
	end

	assign do_insert = (op_t'(op_q) == OP_TRANSMIT) && !known_q && free_found_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (last_rd) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = long_frame ? ST_SCAN : ST_RESULT;
			end
			ST_SCAN: begin
				if (last_rd) state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_INSERT;
			ST_INSERT: state_d = ST_RESULT;
			ST_RESULT: begin
				if (!res_valid_q || result.ready) state_d = ST_IDLE;
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer: handshake and RAM write port
	always_comb begin
		item.ready = 1'b0;
		load_res   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = idx_s1;
		mem_wdata  = upd_entry;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = rd_idx_q;
				mem_wdata = '0;
			end
			ST_IDLE:  item.ready = 1'b1;
			ST_SCAN, ST_DRAIN: begin
				mem_we = vld_s1 && upd_we;
			end
			ST_INSERT: begin
				mem_we    = do_insert;
				mem_waddr = free_idx_q;
				mem_wdata = '{used: live_q, expiry: exp_q, address: src_q};
			end
			ST_RESULT: load_res = !res_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_SCAN);
			if (accept) begin
				rd_idx_q <= '0;
			end else if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				rd_idx_q <= last_rd ? '0 : rd_idx_q + 1'b1;
			end
		end
	end

	// Capture the header and walk results
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (accept) begin
			op_q         <= item.operation;
			dst_q        <= item.dest_address;
			src_q        <= item.source_address;
			len_q        <= item.frame_length;
			now_q        <= item.current_time;
			exp_q        <= exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
			live_q       <= (life_q != '0) && (item.current_time != '1);
			known_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (vld_s1) begin
			if (hit) known_q <= 1'b1;
			if (is_free && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
	end

	// Verdict; a transmitted header reports only sender_known and table_full
	always_comb begin
		res_d.sender_known  = known_q;
		res_d.table_full    = (op_t'(op_q) == OP_TRANSMIT) && (len_q >= HEADER_BYTES)
		                   && !known_q && !free_found_q;
		res_d.frame_valid   = (op_t'(op_q) == OP_RECEIVE) && cls.valid;
		res_d.group_address = (op_t'(op_q) == OP_RECEIVE) && cls.group;
		res_d.for_station   = (op_t'(op_q) == OP_RECEIVE) && cls.mine;
		res_d.accepted      = (op_t'(op_q) == OP_RECEIVE) && !known_q && cls.valid
		                   && (prom_q || cls.mine);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) res_q <= res_d;
	end

	assign result.valid         = res_valid_q;
	assign result.accepted      = res_q.accepted;
	assign result.sender_known  = res_q.sender_known;
	assign result.frame_valid   = res_q.frame_valid;
	assign result.group_address = res_q.group_address;
	assign result.for_station   = res_q.for_station;
	assign result.table_full    = res_q.table_full;

endmodule

`default_nettype wire

// ===== hdl/mlrf_checker.sv =====
// Port-level checks on the loopback receive filter, bound to its top level.
`default_nettype none

module mlrf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic accepted,
	input wire logic sender_known,
	input wire logic frame_valid,
	input wire logic group_address,
	input wire logic for_station,
	input wire logic table_full
);

	// one header at a time: no acceptance straight after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("header accepted while the previous one is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(sender_known)
		&& $stable(frame_valid) && $stable(table_full))
		else $error("stalled result changed");

	a_loopback_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sender_known |-> !accepted)
		else $error("known sender delivered to host");

	a_full_tx_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !frame_valid && !accepted && !group_address)
		else $error("table full reported on a received frame");

	a_station_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (for_station || accepted) |-> frame_valid)
		else $error("invalid frame marked for station or delivered");

endmodule

bind mac_loopback_receive_filter mlrf_checker u_mlrf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.accepted      (result.accepted),
	.sender_known  (result.sender_known),
	.frame_valid   (result.frame_valid),
	.group_address (result.group_address),
	.for_station   (result.for_station),
	.table_full    (result.table_full)
);

`default_nettype wire

// ===== sim/tb_mac_loopback_receive_filter.sv =====
// Self-checking testbench for the loopback receive filter and its aging source MAC table.
`default_nettype none

module tb_mac_loopback_receive_filter;
	timeunit 1ns;
	timeprecision 1ps;

	import mlrf_pkg::*;

	localparam int ENTRIES = TABLE_ENTRIES_DEF;
	// Idle cycles without any transaction before the run is declared hung; the limit covers
	// the walk of one header plus the largest gap and stall that the bench draws.
	localparam int HANG_LIMIT = 1000;

	localparam logic [MAC_W-1:0] ALL_ONES  = {MAC_W{1'b1}};
	localparam logic [MAC_W-1:0] GROUP_MSK = MAC_W'(1) << GROUP_BIT;
	localparam logic [MAC_W-1:0] MAC_A     = 48'h02_11_22_33_44_55;
	localparam logic [MAC_W-1:0] MAC_B     = 48'h00_AA_BB_CC_DD_EE;
	localparam logic [MAC_W-1:0] MAC_C     = 48'h06_10_20_30_40_50;
	localparam logic [MAC_W-1:0] MAC_MCAST = 48'h01_00_5E_00_00_01;
	localparam logic [TIME_W-1:0] EPOCH    = 48'h2_0000_0000;

	// Predicts the verdict of every accepted header and holds those not yet returned.
	class verdict_scoreboard;
		logic [MAC_W-1:0]  station;
		logic              promisc;
		logic [LIFE_W-1:0] lifetime;
		logic [LEN_W-1:0]  max_len;
		logic [MAC_W-1:0]  learned_mac[ENTRIES];
		logic [TIME_W-1:0] expires_at[ENTRIES];
		bit                slot_busy[ENTRIES];
		result_t           due[$];
		int errors, frames, verdicts, loopbacks, full_skips, delivered;

		function new();
			station  = STATION_MAC_RST;
			promisc  = PROMISCUOUS_RST;
			lifetime = LIFETIME_RST;
			max_len  = MAX_LEN_RST;
			foreach (slot_busy[i]) slot_busy[i] = 1'b0;
		endfunction

		function void set_register(cfg_index_t idx, logic [MAC_W-1:0] val);
			case (idx)
				CFG_STATION_MAC: station  = val;
				CFG_PROMISCUOUS: promisc  = val[0];
				CFG_LIFETIME:    lifetime = val[LIFE_W-1:0];
				CFG_MAX_LENGTH:  max_len  = val[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [TIME_W-1:0] expiry_from(logic [TIME_W-1:0] stamp);
			logic [TIME_W:0] sum;
			sum = stamp + lifetime;
			return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
		endfunction

		function void purge(logic [TIME_W-1:0] stamp);
			foreach (slot_busy[i])
				if (slot_busy[i] && expires_at[i] <= stamp) slot_busy[i] = 1'b0;
		endfunction

		function void note_frame(op_t op, logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
				logic [LEN_W-1:0] len, logic [TIME_W-1:0] stamp);
			result_t r;
			logic    hit, placed;
			r = '0;
			hit = 1'b0;
			placed = 1'b0;
			if (len >= HEADER_BYTES) begin
				// refresh every live match, expired or not
				foreach (slot_busy[i])
					if (slot_busy[i] && learned_mac[i] == src) begin
						expires_at[i] = expiry_from(stamp);
						hit = 1'b1;
					end
				r.sender_known = hit;
				if (op == OP_TRANSMIT) begin
					if (!hit) begin
						foreach (slot_busy[i])
							if (!placed && (!slot_busy[i] || expires_at[i] <= stamp)) begin
								slot_busy[i]   = 1'b1;
								learned_mac[i] = src;
								expires_at[i]  = expiry_from(stamp);
								placed = 1'b1;
							end
						r.table_full = !placed;
					end
					purge(stamp);
				end else begin
					purge(stamp);
					if (len <= max_len) begin
						r.frame_valid   = !(src == ALL_ONES || src == '0 || src == dst);
						r.group_address = dst == ALL_ONES || dst[GROUP_BIT];
						r.for_station   = r.frame_valid && (r.group_address || dst == station);
					end
					r.accepted = !hit && r.frame_valid && (promisc || r.for_station);
				end
			end
			frames++;
			if (op == OP_RECEIVE && hit) loopbacks++;
			if (r.table_full) full_skips++;
			if (r.accepted) delivered++;
			due.push_back(r);
		endfunction

		function void compare_bit(string name, logic want, logic got);
			if (want !== got) begin
				$error("%s: expected %0b, got %0b", name, want, got);
				errors++;
			end
		endfunction

		function void check_verdict(result_t got);
			result_t want;
			if (due.size() == 0) begin
				$error("verdict %0h arrived with none outstanding", got);
				errors++;
				return;
			end
			want = due.pop_front();
			verdicts++;
			compare_bit("accepted", want.accepted, got.accepted);
			compare_bit("sender_known", want.sender_known, got.sender_known);
			compare_bit("frame_valid", want.frame_valid, got.frame_valid);
			compare_bit("group_address", want.group_address, got.group_address);
			compare_bit("for_station", want.for_station, got.for_station);
			compare_bit("table_full", want.table_full, got.table_full);
		endfunction
	endclass

	// One register setting plus the shape of the traffic that runs under it
	typedef struct {
		logic [MAC_W-1:0]  station;
		logic              prom;
		logic [LIFE_W-1:0] life;
		logic [LEN_W-1:0]  max_len;
		int unsigned       step;      // largest time advance between headers, before the occasional twentyfold leap
		int                items;
		int                pool;      // distinct source MACs in play
		int                tx_pct;    // share of non-noise headers that transmit
		bit                gaps;      // random idling on both channels
		bit                fill;      // open with a burst of distinct transmits
		bit                near_end;  // run at the top of the time range
	} phase_cfg_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	cfg_index_t        cfg_index;
	logic [MAC_W-1:0]  cfg_data;
	logic [TIME_W-1:0] stamp;
	bit                gaps_on;
	int                stall_left;
	int                idle_cycles;
	int                settings_used;
	phase_cfg_t        ph;

	verdict_scoreboard sb = new;

	mlrf_item_if   item_ch();
	mlrf_result_if res_ch();

	mac_loopback_receive_filter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (res_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [MAC_W-1:0] rand_mac();
		return {$urandom, 16'($urandom)};
	endfunction

	// Saturate at the top of the 48-bit time range so stamps stay monotonic
	function automatic logic [TIME_W-1:0] advance(logic [TIME_W-1:0] t, logic [TIME_W-1:0] inc);
		logic [TIME_W:0] sum;
		sum = t + inc;
		return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	endfunction

	// Present one header and hold it until the transaction completes. Valid is only
	// lowered when a gap follows, so back-to-back headers keep it high throughout.
	task automatic send_frame(op_t op, logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
			logic [LEN_W-1:0] len, logic [TIME_W-1:0] t);
		int gap;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.operation      <= op;
		item_ch.dest_address   <= dst;
		item_ch.source_address <= src;
		item_ch.frame_length   <= len;
		item_ch.current_time   <= t;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_frame(op, dst, src, len, t);
	endtask

	// Hold off the sender until every verdict is back, then let the block settle
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(cfg_index_t idx, logic [MAC_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic apply_settings(phase_cfg_t p);
		write_register(CFG_STATION_MAC, p.station);
		write_register(CFG_PROMISCUOUS, MAC_W'(p.prom));
		write_register(CFG_LIFETIME, MAC_W'(p.life));
		write_register(CFG_MAX_LENGTH, MAC_W'(p.max_len));
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Hand-picked headers under the reset defaults (station 0, promiscuous, lifetime
	// 60000, maximum length 1514)
	task automatic directed_headers();
		gaps_on <= 1'b1;
		// short frames never touch the table
		send_frame(OP_TRANSMIT, MAC_B, MAC_A, 16'd0, 48'd0);
		send_frame(OP_RECEIVE, ALL_ONES, MAC_B, 16'd13, 48'd5);
		// learn, then refresh the same source
		send_frame(OP_TRANSMIT, MAC_B, MAC_A, HEADER_BYTES, 48'd10);
		send_frame(OP_TRANSMIT, MAC_B, MAC_A, 16'd60, 48'd20);
		// our own source coming back: drop as loopback but still classify
		send_frame(OP_RECEIVE, ALL_ONES, MAC_A, 16'd64, 48'd30);
		// broadcast, multicast at the length limit, unicast just past it
		send_frame(OP_RECEIVE, ALL_ONES, MAC_B, 16'd64, 48'd40);
		send_frame(OP_RECEIVE, MAC_MCAST, MAC_B, 16'd1514, 48'd50);
		send_frame(OP_RECEIVE, '0, MAC_B, 16'd1515, 48'd60);
		// unicast to the station address at the minimum length
		send_frame(OP_RECEIVE, '0, MAC_B, HEADER_BYTES, 48'd70);
		// invalid sources: all ones, all zeros, equal to destination
		send_frame(OP_RECEIVE, MAC_A, ALL_ONES, 16'd100, 48'd80);
		send_frame(OP_RECEIVE, ALL_ONES, '0, 16'd100, 48'd90);
		send_frame(OP_RECEIVE, MAC_B, MAC_B, 16'd100, 48'd100);
		send_frame(OP_RECEIVE, MAC_A, MAC_B, 16'hFFFF, 48'd110);
		// learn the degenerate sources too, then see one looped back
		send_frame(OP_TRANSMIT, '0, ALL_ONES, 16'hFFFF, 48'd120);
		send_frame(OP_TRANSMIT, ALL_ONES, '0, HEADER_BYTES, 48'd130);
		send_frame(OP_RECEIVE, ALL_ONES, '0, 16'd64, 48'd140);
		// expiry reached but not yet purged: the match still refreshes
		send_frame(OP_RECEIVE, ALL_ONES, MAC_A, 16'd64, 48'd60030);
		// long after expiry: insert reuses the lowest expired slot, the old
		// source then goes through as a stranger
		send_frame(OP_TRANSMIT, MAC_B, MAC_C, 16'd64, 48'd200000);
		send_frame(OP_RECEIVE, ALL_ONES, MAC_A, 16'd64, 48'd200000);
		stamp = 48'd200000;
	endtask

	task automatic run_phase(phase_cfg_t p);
		logic [MAC_W-1:0]  pool[128];
		logic [MAC_W-1:0]  dst, src;
		logic [LEN_W-1:0]  len;
		logic [TIME_W-1:0] inc;
		int unsigned       top_len;
		op_t               op;
		drain();
		apply_settings(p);
		gaps_on <= p.gaps;
		// leap ahead so most entries from earlier settings have aged out
		stamp = p.near_end ? ALL_ONES - EPOCH : advance(stamp, EPOCH);
		for (int i = 0; i < p.pool; i++) pool[i] = rand_mac();
		top_len = (p.max_len < HEADER_BYTES) ? HEADER_BYTES : p.max_len;
		for (int n = 0; n < p.items; n++) begin
			inc = $urandom_range(0, p.step);
			if ($urandom_range(0, 99) < 3) inc = inc * 20;
			stamp = advance(stamp, inc);
			if (p.fill && n < 70) begin
				// distinct sources in a row, enough to overflow the table
				op  = OP_TRANSMIT;
				src = pool[n % p.pool];
				dst = rand_mac();
				len = LEN_W'($urandom_range(HEADER_BYTES, 200));
			end else if ($urandom_range(0, 99) < 15) begin
				// noise: every field drawn at random
				op  = op_t'($urandom_range(0, 1));
				dst = rand_mac();
				src = rand_mac();
				len = LEN_W'($urandom);
			end else begin
				op = ($urandom_range(0, 99) < p.tx_pct) ? OP_TRANSMIT : OP_RECEIVE;
				if ($urandom_range(0, 99) < 5)
					src = $urandom_range(0, 1) ? ALL_ONES : '0;
				else
					src = pool[$urandom_range(0, p.pool - 1)];
				case ($urandom_range(0, 4))
					0: dst = p.station;
					1: dst = ALL_ONES;
					2: dst = rand_mac() | GROUP_MSK;
					3: dst = rand_mac() & ~GROUP_MSK;
					default: dst = src;
				endcase
				case ($urandom_range(0, 99)) inside
					[0:7]:   len = LEN_W'($urandom_range(0, HEADER_BYTES - 1));
					[8:14]:  len = LEN_W'($urandom_range(top_len, 16'hFFFF));
					default: len = LEN_W'($urandom_range(HEADER_BYTES, top_len));
				endcase
			end
			send_frame(op, dst, src, len, stamp);
		end
	endtask

	// Result side: check each verdict as it is taken, then draw the next stall
	always @(posedge clk) begin : verdict_sink
		int stall_draw;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				sb.check_verdict(result_t'({res_ch.accepted, res_ch.sender_known,
					res_ch.frame_valid, res_ch.group_address, res_ch.for_station,
					res_ch.table_full}));
				stall_draw = gaps_on ? $urandom_range(0, 8) : 0;
				stall_left   <= stall_draw;
				res_ch.ready <= (stall_draw == 0);
			end else if (!res_ch.ready) begin
				if (stall_left <= 1) res_ch.ready <= 1'b1;
				stall_left <= stall_left - 1;
			end
		end
	end

	// Hang guard: count cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [LIFE_W-1:0] life;
		arst_n                 <= 1'b0;
		cfg_wr_en              <= 1'b0;
		cfg_index              <= CFG_STATION_MAC;
		cfg_data               <= '0;
		item_ch.valid          <= 1'b0;
		item_ch.operation      <= OP_TRANSMIT;
		item_ch.dest_address   <= '0;
		item_ch.source_address <= '0;
		item_ch.frame_length   <= '0;
		item_ch.current_time   <= '0;
		gaps_on                <= 1'b1;
		stamp = '0;
		settings_used = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset keeps item.ready low; send_frame waits it out
		directed_headers();

		// Field order: station, prom, life, max_len, step, items, pool, tx_pct,
		// gaps, fill, near_end
		ph = '{rand_mac(), 1'b0, 32'd200, 16'd1514, 40, 200, 12, 40, 1'b1, 1'b0, 1'b0};
		run_phase(ph);
		// shortest non-zero lifetime, length limit at the header size, station all ones, no idling
		ph = '{ALL_ONES, 1'b1, 32'd1, 16'd14, 2, 120, 8, 40, 1'b0, 1'b0, 1'b0};
		run_phase(ph);
		// longest lifetime: fill the table and keep it full
		ph = '{48'd0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1 << 20, 220, 120, 70,
			1'b1, 1'b1, 1'b0};
		run_phase(ph);
		ph = '{rand_mac(), 1'b1, 32'd5000, 16'd60, 800, 150, 16, 40, 1'b1, 1'b0, 1'b0};
		run_phase(ph);
		// zero lifetime and a limit under the header size: nothing learns, nothing valid
		ph = '{rand_mac(), 1'b1, 32'd0, 16'd13, 3, 100, 8, 50, 1'b0, 1'b0, 1'b0};
		run_phase(ph);
		ph = '{rand_mac(), 1'b0, 32'd1000, 16'd1518, 200, 200, 24, 40, 1'b1, 1'b0, 1'b0};
		run_phase(ph);
		life = $urandom_range(1, 100000);
		ph = '{rand_mac(), 1'($urandom), life, LEN_W'($urandom_range(HEADER_BYTES, 9000)),
			life / 5 + 1, 150, 20, 45, 1'b1, 1'b0, 1'b0};
		run_phase(ph);
		// top of the time range: expiry saturates and stamps reach the ceiling
		ph = '{rand_mac(), 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1 << 26, 150, 16, 45,
			1'b1, 1'b0, 1'b1};
		run_phase(ph);

		drain();
		repeat (ENTRIES + 8) @(posedge clk);

		$display("Covered %0d frame headers under %0d register settings, %0d verdicts checked",
			sb.frames, settings_used, sb.verdicts);
		$display("Loopback drops %0d, deliveries %0d, inserts refused on a full table %0d",
			sb.loopbacks, sb.delivered, sb.full_skips);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== mac_loopback_receive_filter.f =====
hdl/mlrf_pkg.sv
hdl/mlrf_item_if.sv
hdl/mlrf_result_if.sv
hdl/mlrf_ram.sv
hdl/mlrf_classify.sv
hdl/mac_loopback_receive_filter.sv
hdl/mlrf_checker.sv
sim/tb_mac_loopback_receive_filter.sv
